>>> rtl/nvq_pkg.sv
`timescale 1ns / 1ps

package nvq_pkg;

    // Table and datapath sizes
    localparam int NUM_NORMALS    = 162;
    localparam int COMPONENT_BITS = 16;
    localparam int IDX_W          = $clog2(NUM_NORMALS);
    localparam int TAB_W          = 16;
    localparam int PROD_W         = COMPONENT_BITS + TAB_W;
    localparam int DOT_W          = PROD_W + 2;

    typedef logic signed [TAB_W-1:0] tab_t;

    typedef struct packed {
        tab_t nx;
        tab_t ny;
        tab_t nz;
    } normal_t;

    // Q2.14 magnitudes of the normal components (1.0 = 16384)
    localparam tab_t Z0   = 16'sd0;
    localparam tab_t C525 = 16'sd8614;
    localparam tab_t C851 = 16'sd13937;
    localparam tab_t C443 = 16'sd7256;
    localparam tab_t C239 = 16'sd3913;
    localparam tab_t C864 = 16'sd14159;
    localparam tab_t C295 = 16'sd4837;
    localparam tab_t C955 = 16'sd15654;
    localparam tab_t C309 = 16'sd5063;
    localparam tab_t C500 = 16'sd8192;
    localparam tab_t C809 = 16'sd13255;
    localparam tab_t C162 = 16'sd2662;
    localparam tab_t C263 = 16'sd4307;
    localparam tab_t C951 = 16'sd15582;
    localparam tab_t C1   = 16'sd16384;
    localparam tab_t C148 = 16'sd2419;
    localparam tab_t C717 = 16'sd11740;
    localparam tab_t C682 = 16'sd11169;
    localparam tab_t C588 = 16'sd9630;
    localparam tab_t C425 = 16'sd6969;
    localparam tab_t C688 = 16'sd11275;

    // 162-entry unit normal set
    localparam normal_t NORMAL_TABLE [NUM_NORMALS] = '{
        '{-C525,Z0,C851},'{-C443,C239,C864},'{-C295,Z0,C955},'{-C309,C500,C809},
        '{-C162,C263,C951},'{Z0,Z0,C1},'{Z0,C851,C525},'{-C148,C717,C682},
        '{C148,C717,C682},'{Z0,C525,C851},'{C309,C500,C809},'{C525,Z0,C851},
        '{C295,Z0,C955},'{C443,C239,C864},'{C162,C263,C951},'{-C682,C148,C717},
        '{-C809,C309,C500},'{-C588,C425,C688},'{-C851,C525,Z0},'{-C864,C443,C239},
        '{-C717,C682,C148},'{-C688,C588,C425},'{-C500,C809,C309},'{-C239,C864,C443},
        '{-C425,C688,C588},'{-C717,C682,-C148},'{-C500,C809,-C309},'{-C525,C851,Z0},
        '{Z0,C851,-C525},'{-C239,C864,-C443},'{Z0,C955,-C295},'{-C263,C951,-C162},
        '{Z0,C1,Z0},'{Z0,C955,C295},'{-C263,C951,C162},'{C239,C864,C443},
        '{C263,C951,C162},'{C500,C809,C309},'{C239,C864,-C443},'{C263,C951,-C162},
        '{C500,C809,-C309},'{C851,C525,Z0},'{C717,C682,C148},'{C717,C682,-C148},
        '{C525,C851,Z0},'{C425,C688,C588},'{C864,C443,C239},'{C688,C588,C425},
        '{C809,C309,C500},'{C682,C148,C717},'{C588,C425,C688},'{C955,C295,Z0},
        '{C1,Z0,Z0},'{C951,C162,C263},'{C851,-C525,Z0},'{C955,-C295,Z0},
        '{C864,-C443,C239},'{C951,-C162,C263},'{C809,-C309,C500},'{C682,-C148,C717},
        '{C851,Z0,C525},'{C864,C443,-C239},'{C809,C309,-C500},'{C951,C162,-C263},
        '{C525,Z0,-C851},'{C682,C148,-C717},'{C682,-C148,-C717},'{C851,Z0,-C525},
        '{C809,-C309,-C500},'{C864,-C443,-C239},'{C951,-C162,-C263},'{C148,C717,-C682},
        '{C309,C500,-C809},'{C425,C688,-C588},'{C443,C239,-C864},'{C588,C425,-C688},
        '{C688,C588,-C425},'{-C148,C717,-C682},'{-C309,C500,-C809},'{Z0,C525,-C851},
        '{-C525,Z0,-C851},'{-C443,C239,-C864},'{-C295,Z0,-C955},'{-C162,C263,-C951},
        '{Z0,Z0,-C1},'{C295,Z0,-C955},'{C162,C263,-C951},'{-C443,-C239,-C864},
        '{-C309,-C500,-C809},'{-C162,-C263,-C951},'{Z0,-C851,-C525},'{-C148,-C717,-C682},
        '{C148,-C717,-C682},'{Z0,-C525,-C851},'{C309,-C500,-C809},'{C443,-C239,-C864},
        '{C162,-C263,-C951},'{C239,-C864,-C443},'{C500,-C809,-C309},'{C425,-C688,-C588},
        '{C717,-C682,-C148},'{C688,-C588,-C425},'{C588,-C425,-C688},'{Z0,-C955,-C295},
        '{Z0,-C1,Z0},'{C263,-C951,-C162},'{Z0,-C851,C525},'{Z0,-C955,C295},
        '{C239,-C864,C443},'{C263,-C951,C162},'{C500,-C809,C309},'{C717,-C682,C148},
        '{C525,-C851,Z0},'{-C239,-C864,-C443},'{-C500,-C809,-C309},'{-C263,-C951,-C162},
        '{-C851,-C525,Z0},'{-C717,-C682,-C148},'{-C717,-C682,C148},'{-C525,-C851,Z0},
        '{-C500,-C809,C309},'{-C239,-C864,C443},'{-C263,-C951,C162},'{-C864,-C443,C239},
        '{-C809,-C309,C500},'{-C688,-C588,C425},'{-C682,-C148,C717},'{-C443,-C239,C864},
        '{-C588,-C425,C688},'{-C309,-C500,C809},'{-C148,-C717,C682},'{-C425,-C688,C588},
        '{-C162,-C263,C951},'{C443,-C239,C864},'{C162,-C263,C951},'{C309,-C500,C809},
        '{C148,-C717,C682},'{Z0,-C525,C851},'{C425,-C688,C588},'{C588,-C425,C688},
        '{C688,-C588,C425},'{-C955,C295,Z0},'{-C951,C162,C263},'{-C1,Z0,Z0},
        '{-C851,Z0,C525},'{-C955,-C295,Z0},'{-C951,-C162,C263},'{-C864,C443,-C239},
        '{-C951,C162,-C263},'{-C809,C309,-C500},'{-C864,-C443,-C239},'{-C951,-C162,-C263},
        '{-C809,-C309,-C500},'{-C682,C148,-C717},'{-C682,-C148,-C717},'{-C851,Z0,-C525},
        '{-C688,C588,-C425},'{-C588,C425,-C688},'{-C425,C688,-C588},'{-C425,-C688,-C588},
        '{-C588,-C425,-C688},'{-C688,-C588,-C425}
    };

endpackage

>>> rtl/normal_vector_quantizer_core.sv
`timescale 1ns / 1ps

// Nearest stored unit normal by dot product.
// Input channel (s_valid/s_ready): one direction vector per request, three
// signed Q2.14 components. Result channel (m_valid/m_ready): the index
// 0..161 of the table normal with the largest dot product; ties keep the
// lower index and index 0 is returned when no dot product is positive.
// The scan walks the normal ROM one entry per cycle through a
// single read port (162 reads), followed by product, sum and compare
// stages. One request is processed at a time; s_ready rises again when the
// result is loaded into the output register, so a new request is not
// accepted until the previous result has been loaded.
// The output register holds the result until m_ready; a new input may be
// accepted while it waits. If the receiver stalls past the end of the next
// scan, that scan's result is held internally until the output frees up.
// Reset (aresetn low, synchronous) returns the block to idle and drops
// m_valid; nothing else needs clearing.
module normal_vector_quantizer_core (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [nvq_pkg::COMPONENT_BITS-1:0]  s_dir_x,
    input  logic signed [nvq_pkg::COMPONENT_BITS-1:0]  s_dir_y,
    input  logic signed [nvq_pkg::COMPONENT_BITS-1:0]  s_dir_z,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic        [nvq_pkg::IDX_W-1:0]           m_normal_index
);
    import nvq_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_NORMALS - 1);

    logic [1:0]                       state_reg, state_next;
    logic [IDX_W-1:0]                 addr_reg;
    logic signed [COMPONENT_BITS-1:0] x_reg, y_reg, z_reg;

    // stage 1: ROM data
    normal_t                          rom_q_reg;
    logic                             v1_reg, last1_reg;
    logic [IDX_W-1:0]                 idx1_reg;
    // stage 2: products
    logic signed [PROD_W-1:0]         px_reg, py_reg, pz_reg;
    logic                             v2_reg, last2_reg;
    logic [IDX_W-1:0]                 idx2_reg;
    // stage 3: dot product
    logic signed [DOT_W-1:0]          dot_reg;
    logic                             v3_reg, last3_reg;
    logic [IDX_W-1:0]                 idx3_reg;
    // running best
    logic signed [DOT_W-1:0]          best_dot_reg;
    logic [IDX_W-1:0]                 best_idx_reg;

    logic                             m_valid_reg;
    logic [IDX_W-1:0]                 m_index_reg;

    logic in_fire, issue, out_free;

    assign s_ready        = (state_reg == ST_IDLE);
    assign in_fire        = s_valid && s_ready;
    assign issue          = (state_reg == ST_SCAN);
    assign out_free       = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_normal_index = m_index_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_SCAN;
            ST_SCAN:  if (addr_reg == LAST_IDX) state_next = ST_DRAIN;
            ST_DRAIN: if (v3_reg && last3_reg) state_next = ST_PUSH;
            ST_PUSH:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (state_reg == ST_PUSH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input capture and ROM address
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            x_reg    <= s_dir_x;
            y_reg    <= s_dir_y;
            z_reg    <= s_dir_z;
            addr_reg <= '0;
        end else if (issue) begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    // synchronous normal ROM, one read per cycle
    always_ff @(posedge aclk) begin
        rom_q_reg <= NORMAL_TABLE[addr_reg];
        idx1_reg  <= addr_reg;
        last1_reg <= (addr_reg == LAST_IDX);
    end

    // products and sum
    always_ff @(posedge aclk) begin
        px_reg    <= PROD_W'(x_reg) * PROD_W'(rom_q_reg.nx);
        py_reg    <= PROD_W'(y_reg) * PROD_W'(rom_q_reg.ny);
        pz_reg    <= PROD_W'(z_reg) * PROD_W'(rom_q_reg.nz);
        idx2_reg  <= idx1_reg;
        last2_reg <= last1_reg;
        dot_reg   <= DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
        idx3_reg  <= idx2_reg;
        last3_reg <= last2_reg;
    end

    // strictly-greater compare; best starts at zero, index 0
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            best_dot_reg <= '0;
            best_idx_reg <= '0;
        end else if (v3_reg && (dot_reg > best_dot_reg)) begin
            best_dot_reg <= dot_reg;
            best_idx_reg <= idx3_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PUSH && out_free) begin
            m_index_reg <= best_idx_reg;
        end
    end

    // checks
    a_out_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_index <= LAST_IDX))
        else $error("result index beyond table");

    a_pipe_empty_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("scan pipeline busy while idle");

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_SCAN) && (addr_reg == '0))
        else $error("scan did not start at entry 0");

    a_push_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_PUSH) |-> $past(v3_reg && last3_reg))
        else $error("result pushed before last compare");

    a_best_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (best_dot_reg >= 0))
        else $error("running best went negative");

endmodule
